/* hdl/pts_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic timer scheduler package
// Shared types, codes and constants for the timer scheduler block.
// ----------------------------------------------------------------------------
package pts_pkg;

   localparam logic [1:0] KIND_ADD   = 2'd0;
   localparam logic [1:0] KIND_RUN   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_BAD_INTERVAL = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL   = 2'd2;

   localparam logic CSR_UTC_OFFSET = 1'b0;

   localparam int ALIGN_W  = 17;
   localparam int MOD_DW   = 33;
   localparam int MOD_CW   = $clog2(MOD_DW + 1);

   localparam logic [4:0]  RESULT_CAP   = 5'd16;
   localparam logic [10:0] WAIT_MAX_MS  = 11'd2000;
   localparam logic [31:0] ALIGN_MIN_MS = 32'd1000;
   localparam logic signed [32:0] SKEW_LIMIT = 33'sd10;
   localparam logic signed [63:0] ALIGN_USEC = 64'sd10000;
   localparam logic signed [63:0] WAIT_MAX_US = 64'sd2000000;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [9:0]  USEC_PER_MS  = 10'd1000;
   localparam logic signed [33:0] SEC_PER_HOUR = 34'sd3600;
   // ceil(2^31 / 1000); exact quotient by 1000 for values below 2^21
   localparam logic [21:0] MS_RECIP     = 22'd2147484;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] now_sec;
      logic [19:0] now_usec;
      logic [31:0] interval_ms;
      logic [16:0] align_seconds;
      logic [30:0] call_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [5:0]         slot;
      logic               fired;
      logic signed [31:0] calls_left;
      logic [10:0]        wait_ms;
      logic               skew_seen;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0]        ivl;
      logic [16:0]        align;
      logic [30:0]        rem;
      logic signed [63:0] next;
   } entry_type;

   typedef enum logic [2:0] {
      RS_ADD_OK, RS_BAD, RS_FULL, RS_NOFIRE, RS_QUERY, RS_ZERO
   } res_sel_type;

   typedef struct packed {
      logic        load;
      logic        skew_chk;
      logic        idx_clr;
      logic        idx_inc;
      logic        rd;
      logic        src_item;
      logic        src_ram;
      logic        mod_start;
      logic        wr_arm;
      logic        wr_fire;
      logic        min_upd;
      logic        pend_load;
      res_sel_type pend_sel;
      logic        push_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       ivl_zero;
      logic       any_valid;
      logic       slot_valid;
      logic       idx_last;
      logic       aligned;
      logic       mod_busy;
      logic       due;
      logic       skew_now;
      logic       pend_valid;
      logic       out_free;
      logic       fire_cap;
   } stat_type;

endpackage

/* hdl/pts_ram.sv */
// ----------------------------------------------------------------------------
// Timer table RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/pts_mod.sv */
// ----------------------------------------------------------------------------
// Alignment modulo unit
// Bit-serial restoring remainder of a signed second count by the alignment.
// ----------------------------------------------------------------------------
module pts_mod import pts_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MOD_DW-1:0]  dividend,
   input  logic               negative,
   input  logic [ALIGN_W-1:0] divisor,
   output logic               busy,
   output logic [ALIGN_W-1:0] remainder
);

   logic                busy_ff, busy_in;
   logic [MOD_CW-1:0]   cnt_ff, cnt_in;
   logic [MOD_DW-1:0]   quo_ff, quo_in;
   logic [ALIGN_W-1:0]  rem_ff, rem_in;
   logic [ALIGN_W-1:0]  div_ff, div_in;
   logic                neg_ff, neg_in;
   logic [ALIGN_W:0]    trial;
   logic                fits;

   assign trial = {rem_ff, quo_ff[MOD_DW-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MOD_CW'(MOD_DW);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         neg_in  = negative;
      end else if (busy_ff) begin
         quo_in = {quo_ff[MOD_DW-2:0], 1'b0};
         rem_in = fits ? ALIGN_W'(trial - {1'b0, div_ff}) : ALIGN_W'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MOD_CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   // Truncated remainder of a negative value is folded to the positive range.
   assign busy      = busy_ff;
   assign remainder = (neg_ff && rem_ff != '0) ? div_ff - rem_ff : rem_ff;

endmodule

/* hdl/pts_ctrl.sv */
// ----------------------------------------------------------------------------
// Timer scheduler controller
// Sequences add, re-arm, fire and minimum walks over the timer slots.
// ----------------------------------------------------------------------------
module pts_ctrl import pts_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_PREP, S_PREP2, S_DISP, S_ADD_SCAN, S_RA_RD, S_RA_LAT,
      S_ARM_START, S_ARM_MOD, S_ARM_MUL, S_ARM_WR, S_F_RD, S_F_CHK,
      S_F_MUL, S_F_UPD, S_RUN_END, S_M_RD, S_M_CHK, S_Q_WAIT, S_Q_RES, S_FIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      cmd.pend_sel = RS_ZERO;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP:  state_in = S_PREP2;
         S_PREP2: state_in = S_DISP;
         S_DISP: begin
            case (stat.kind)
               KIND_ADD: begin
                  if (stat.ivl_zero) begin
                     cmd.pend_load = 1'b1;
                     cmd.pend_sel  = RS_BAD;
                     state_in      = S_FIN;
                  end else begin
                     cmd.idx_clr = 1'b1;
                     state_in    = S_ADD_SCAN;
                  end
               end
               KIND_RUN: begin
                  if (!stat.any_valid) begin
                     cmd.pend_load = 1'b1;
                     cmd.pend_sel  = RS_NOFIRE;
                     state_in      = S_FIN;
                  end else begin
                     cmd.skew_chk = 1'b1;
                     cmd.idx_clr  = 1'b1;
                     state_in     = stat.skew_now ? S_RA_RD : S_F_RD;
                  end
               end
               KIND_QUERY: begin
                  cmd.skew_chk = 1'b1;
                  cmd.idx_clr  = 1'b1;
                  state_in     = stat.skew_now ? S_RA_RD : S_M_RD;
               end
               default: begin
                  cmd.pend_load = 1'b1;
                  cmd.pend_sel  = RS_ZERO;
                  state_in      = S_FIN;
               end
            endcase
         end
         S_ADD_SCAN: begin
            if (!stat.slot_valid) begin
               cmd.src_item = 1'b1;
               state_in     = S_ARM_START;
            end else if (stat.idx_last) begin
               cmd.pend_load = 1'b1;
               cmd.pend_sel  = RS_FULL;
               state_in      = S_FIN;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_RA_RD: begin
            if (stat.slot_valid) begin
               cmd.rd   = 1'b1;
               state_in = S_RA_LAT;
            end else if (stat.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = (stat.kind == KIND_RUN) ? S_F_RD : S_M_RD;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_RA_LAT: begin
            cmd.src_ram = 1'b1;
            state_in    = S_ARM_START;
         end
         S_ARM_START: begin
            if (stat.aligned) begin
               cmd.mod_start = 1'b1;
               state_in      = S_ARM_MOD;
            end else begin
               state_in = S_ARM_MUL;
            end
         end
         S_ARM_MOD: begin
            if (!stat.mod_busy) begin
               state_in = S_ARM_MUL;
            end
         end
         S_ARM_MUL: state_in = S_ARM_WR;
         S_ARM_WR: begin
            cmd.wr_arm = 1'b1;
            if (stat.kind == KIND_ADD) begin
               cmd.pend_load = 1'b1;
               cmd.pend_sel  = RS_ADD_OK;
               state_in      = S_FIN;
            end else if (stat.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = (stat.kind == KIND_RUN) ? S_F_RD : S_M_RD;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_RA_RD;
            end
         end
         S_F_RD: begin
            if (stat.slot_valid && !stat.fire_cap) begin
               cmd.rd   = 1'b1;
               state_in = S_F_CHK;
            end else if (stat.idx_last) begin
               state_in = S_RUN_END;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_F_CHK: begin
            if (stat.due) begin
               cmd.src_ram = 1'b1;
               state_in    = S_F_MUL;
            end else if (stat.idx_last) begin
               state_in = S_RUN_END;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_F_RD;
            end
         end
         S_F_MUL: state_in = S_F_UPD;
         S_F_UPD: begin
            if (!stat.pend_valid || stat.out_free) begin
               cmd.wr_fire = 1'b1;
               if (stat.idx_last) begin
                  state_in = S_RUN_END;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_F_RD;
               end
            end
         end
         S_RUN_END: begin
            if (!stat.pend_valid) begin
               cmd.pend_load = 1'b1;
               cmd.pend_sel  = RS_NOFIRE;
            end
            state_in = S_FIN;
         end
         S_M_RD: begin
            if (stat.slot_valid) begin
               cmd.rd   = 1'b1;
               state_in = S_M_CHK;
            end else if (stat.idx_last) begin
               state_in = S_Q_WAIT;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         S_M_CHK: begin
            cmd.min_upd = 1'b1;
            if (stat.idx_last) begin
               state_in = S_Q_WAIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_M_RD;
            end
         end
         S_Q_WAIT: state_in = S_Q_RES;
         S_Q_RES: begin
            cmd.pend_load = 1'b1;
            cmd.pend_sel  = RS_QUERY;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.push_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hdl/pts_dp.sv */
// ----------------------------------------------------------------------------
// Timer scheduler datapath
// Item registers, timer table, arming arithmetic and the result stages.
// ----------------------------------------------------------------------------
module pts_dp import pts_pkg::*; #(
   parameter int TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  req_type     req_data,
   input  logic [5:0]  utc_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

   req_type              item_ff;
   logic [51:0]          nowsec_us_ff;
   logic signed [63:0]   now_us_ff;
   logic signed [33:0]   t_ff;
   logic [31:0]          last_clock_ff;
   logic                 skew_ff;
   logic [IW-1:0]        idx_ff;
   logic [TIMERS-1:0]    valid_ff;
   entry_type            src_ff;
   entry_type            rdata;
   entry_type            wdata;
   logic [36:0]          rus_ff;
   logic [41:0]          ivl_us_ff;
   logic                 found_ff;
   logic signed [63:0]   best_ff;
   logic [42:0]          qprod_ff;
   rsp_type              pend_ff, out_ff;
   logic                 pend_valid_ff, out_valid_ff;
   logic [4:0]           nfire_ff;

   logic signed [32:0]   diff;
   logic                 skew_now;
   logic [MOD_DW-1:0]    mag;
   logic                 mod_busy;
   logic [ALIGN_W-1:0]   r;
   logic                 aligned;
   logic signed [63:0]   base;
   logic signed [63:0]   arm_next;
   logic [30:0]          rem_new;
   logic signed [31:0]   left;
   logic                 due;
   logic signed [63:0]   d;
   logic                 lt, big;
   logic [10:0]          wait_raw, wait_ms;
   logic                 out_free;
   rsp_type              pend_in;
   rsp_type              pend_last;

   assign diff     = $signed({1'b0, item_ff.now_sec}) - $signed({1'b0, last_clock_ff});
   assign skew_now = (diff <= -SKEW_LIMIT) || (diff >= SKEW_LIMIT);
   assign mag      = t_ff[33] ? MOD_DW'(-t_ff) : MOD_DW'(t_ff);

   pts_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mag),
      .negative  (t_ff[33]),
      .divisor   (src_ff.align),
      .busy      (mod_busy),
      .remainder (r)
   );

   assign aligned  = (src_ff.ivl >= ALIGN_MIN_MS) && (src_ff.align != '0);
   assign base     = aligned ? $signed({12'd0, nowsec_us_ff}) - $signed({27'd0, rus_ff})
                               + ALIGN_USEC
                             : now_us_ff;
   assign arm_next = base + $signed({22'd0, ivl_us_ff});
   assign rem_new  = (src_ff.rem != '0) ? src_ff.rem - 1'b1 : '0;
   assign left     = (src_ff.rem != '0) ? $signed({1'b0, rem_new}) : -32'sd1;
   assign due      = rdata.next <= now_us_ff;

   always_comb begin
      wdata = src_ff;
      if (cmd.wr_fire) begin
         wdata.rem  = rem_new;
         wdata.next = src_ff.next + $signed({22'd0, ivl_us_ff});
      end else begin
         wdata.next = arm_next;
      end
   end

   pts_ram #(.WIDTH($bits(entry_type)), .DEPTH(TIMERS)) u_table (
      .clock (clock),
      .we    (cmd.wr_arm || cmd.wr_fire),
      .waddr (idx_ff),
      .wdata (wdata),
      .re    (cmd.rd),
      .raddr (idx_ff),
      .rdata (rdata)
   );

   // Wait to the earliest expiry.
   assign d        = best_ff - now_us_ff;
   assign lt       = best_ff < now_us_ff;
   assign big      = d >= WAIT_MAX_US;
   assign wait_raw = !found_ff ? WAIT_MAX_MS :
                     lt        ? 11'd0 :
                     big       ? WAIT_MAX_MS : qprod_ff[41:31];
   assign wait_ms  = (wait_raw == '0) ? 11'd1 : wait_raw;

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      pend_in = '0;
      case (cmd.pend_sel)
         RS_ADD_OK: begin
            pend_in.status = ST_OK;
            pend_in.slot   = 6'(idx_ff);
         end
         RS_BAD:    pend_in.status = ST_BAD_INTERVAL;
         RS_FULL:   pend_in.status = ST_TABLE_FULL;
         RS_NOFIRE: pend_in.skew_seen = skew_ff;
         RS_QUERY: begin
            pend_in.wait_ms   = wait_ms;
            pend_in.skew_seen = skew_ff;
         end
         default:   pend_in = '0;
      endcase
      if (cmd.wr_fire) begin
         pend_in            = '0;
         pend_in.slot       = 6'(idx_ff);
         pend_in.fired      = 1'b1;
         pend_in.calls_left = left;
         pend_in.skew_seen  = skew_ff;
      end
   end

   // The final result of a transaction leaves with its last flag set.
   always_comb begin
      pend_last      = pend_ff;
      pend_last.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_clock_ff <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.skew_chk) begin
            last_clock_ff <= item_ff.now_sec;
         end
         if (cmd.wr_arm) begin
            valid_ff[idx_ff] <= 1'b1;
         end else if (cmd.wr_fire && src_ff.rem == 31'd1) begin
            valid_ff[idx_ff] <= 1'b0;
         end
         if (rsp_valid && rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.push_last || (cmd.wr_fire && pend_valid_ff)) begin
            out_valid_ff <= 1'b1;
         end
         if (cmd.pend_load || cmd.wr_fire) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.push_last) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff  <= req_data;
         skew_ff  <= 1'b0;
         found_ff <= 1'b0;
         nfire_ff <= '0;
      end else begin
         if (cmd.skew_chk) begin
            skew_ff <= skew_now;
         end
         if (cmd.min_upd && (!found_ff || rdata.next < best_ff)) begin
            found_ff <= 1'b1;
            best_ff  <= rdata.next;
         end
         if (cmd.wr_fire) begin
            nfire_ff <= nfire_ff + 1'b1;
         end
      end
      nowsec_us_ff <= 52'(item_ff.now_sec * USEC_PER_SEC);
      now_us_ff    <= $signed({12'd0, nowsec_us_ff}) + $signed({44'd0, item_ff.now_usec});
      t_ff         <= $signed({2'b00, item_ff.now_sec})
                      + 34'($signed(utc_offset) * SEC_PER_HOUR);
      rus_ff       <= 37'(r * USEC_PER_SEC);
      ivl_us_ff    <= 42'(src_ff.ivl * USEC_PER_MS);
      qprod_ff     <= 43'(d[20:0] * MS_RECIP);
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.src_item) begin
         src_ff.ivl   <= item_ff.interval_ms;
         src_ff.align <= item_ff.align_seconds;
         src_ff.rem   <= item_ff.call_limit;
         src_ff.next  <= '0;
      end else if (cmd.src_ram) begin
         src_ff <= rdata;
      end
      if (cmd.pend_load || cmd.wr_fire) begin
         pend_ff <= pend_in;
      end
      if (cmd.push_last) begin
         out_ff <= pend_last;
      end else if (cmd.wr_fire && pend_valid_ff) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      stat            = '0;
      stat.kind       = item_ff.kind;
      stat.ivl_zero   = item_ff.interval_ms == '0;
      stat.any_valid  = |valid_ff;
      stat.slot_valid = valid_ff[idx_ff];
      stat.idx_last   = idx_ff == IW'(TIMERS - 1);
      stat.aligned    = aligned;
      stat.mod_busy   = mod_busy;
      stat.due        = due;
      stat.skew_now   = skew_now;
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = out_free;
      stat.fire_cap   = nfire_ff == RESULT_CAP;
   end

endmodule

/* hdl/periodic_timer_scheduler.sv */
// ----------------------------------------------------------------------------
// Periodic timer scheduler
// Timer table with add, run and query transactions and a UTC offset register.
// ----------------------------------------------------------------------------
//  channel   ports                         role
//  req       req_valid/ready, req_data     one add, run or query transaction
//  rsp       rsp_valid/ready, rsp_data     results; last marks the final one
//  csr       csr_psel..csr_pready          utc_offset_hours at byte address 0
//
// An add holds the block while it scans the slots for a free one and arms
// it there, waiting on the bit-serial modulo unit when the first expiry is
// aligned. A run or query sets up, then walks every slot: a run reads each
// occupied slot and updates each one that fires, a query tracks the earliest
// expiry. A clock skew first re-arms each valid timer, through the modulo
// unit when aligned.
// Reset is synchronous and empties the table; the block accepts no
// transaction while one is in progress, and a stalled result stage holds the walk.
// ----------------------------------------------------------------------------
module periodic_timer_scheduler import pts_pkg::*; #(
   parameter int TIMERS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cmd_type    cmd;
   stat_type   stat;
   logic [5:0] offset_ff, offset_in;
   logic       csr_write;

   // The offset register is written in the access phase of an APB write.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == CSR_UTC_OFFSET);
   assign offset_in  = csr_write ? csr_pwdata[5:0] : offset_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_UTC_OFFSET)
                       ? 32'($signed(offset_ff)) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   // The controller sequences each transaction; the datapath holds the table.
   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pts_dp #(.TIMERS(TIMERS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_data   (req_data),
      .utc_offset (offset_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // A transaction occupies the block, so ready drops right after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a transaction was accepted");

   // A firing always reports success and carries no wait.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.fired) |->
      (rsp_data.status == ST_OK && rsp_data.wait_ms == 11'd0))
      else $error("firing result carries a status or a wait");

   // The wait never exceeds its clamp.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.wait_ms <= WAIT_MAX_MS))
      else $error("wait beyond the clamp");

endmodule

/* sim/periodic_timer_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// Periodic timer scheduler testbench
// Drives add, run and query transactions against a predicted timer table and
// checks every result field, across several UTC offset settings.
// ----------------------------------------------------------------------------

// Holds the expected results and a copy of the timer table.
class timer_table_model;
   bit             valid [16];
   bit [31:0]      ivl [16];
   bit [16:0]      align [16];
   bit [30:0]      rem [16];
   longint         next [16];
   bit [31:0]      last_sec;
   int             offset_hours;
   pts_pkg::rsp_type pending [$];
   bit             failed;

   function void clear();
      foreach (valid[i]) valid[i] = 0;
      last_sec = 0;
      offset_hours = 0;
      pending.delete();
      failed = 0;
   endfunction

   function void arm(int i, bit [31:0] s, bit [19:0] us);
      longint bs;
      longint bu;
      longint t;
      longint r;
      bs = s;
      bu = us;
      if (ivl[i] >= 1000 && align[i] > 0) begin
         t = longint'(s) + longint'(offset_hours) * 3600;
         r = t % longint'(align[i]);
         if (r < 0) r += align[i];
         bs -= r;
         bu = 10000;
      end
      next[i] = bs * 1000000 + bu + longint'(ivl[i]) * 1000;
   endfunction

   function bit skew_check(bit [31:0] s, bit [19:0] us);
      longint d;
      bit sk;
      d = longint'(s) - longint'(last_sec);
      sk = (d <= -10) || (d >= 10);
      if (sk)
         for (int i = 0; i < 16; i++)
            if (valid[i]) arm(i, s, us);
      last_sec = s;
      return sk;
   endfunction

   function pts_pkg::rsp_type blank();
      pts_pkg::rsp_type r;
      r = '0;
      r.status = pts_pkg::ST_OK;
      return r;
   endfunction

   // Works out the results of one accepted transaction.
   function void note_request(pts_pkg::req_type q);
      pts_pkg::rsp_type r;
      longint now_us;
      longint best;
      longint w;
      bit any;
      bit sk;
      bit found;
      int n;
      now_us = longint'(q.now_sec) * 1000000 + longint'(q.now_usec);
      r = blank();
      r.last = 1;
      if (q.kind == pts_pkg::KIND_ADD) begin
         if (q.interval_ms == 0) begin
            r.status = pts_pkg::ST_BAD_INTERVAL;
         end else begin
            r.status = pts_pkg::ST_TABLE_FULL;
            for (int i = 0; i < 16; i++)
               if (!valid[i] && r.status == pts_pkg::ST_TABLE_FULL) begin
                  valid[i] = 1;
                  ivl[i] = q.interval_ms;
                  align[i] = q.align_seconds;
                  rem[i] = q.call_limit;
                  arm(i, q.now_sec, q.now_usec);
                  r.status = pts_pkg::ST_OK;
                  r.slot = 6'(i);
               end
         end
         pending.push_back(r);
      end else if (q.kind == pts_pkg::KIND_RUN) begin
         any = 0;
         sk = 0;
         n = 0;
         foreach (valid[i]) if (valid[i]) any = 1;
         if (any) sk = skew_check(q.now_sec, q.now_usec);
         for (int i = 0; i < 16; i++) begin
            if (!valid[i] || next[i] > now_us) continue;
            r = blank();
            r.slot = 6'(i);
            r.fired = 1;
            r.calls_left = (rem[i] > 0) ? 32'(rem[i]) - 1 : -1;
            r.skew_seen = sk;
            pending.push_back(r);
            n++;
            next[i] += longint'(ivl[i]) * 1000;
            if (rem[i] > 0) begin
               rem[i]--;
               if (rem[i] == 0) valid[i] = 0;
            end
         end
         if (n == 0) begin
            r = blank();
            r.skew_seen = sk;
            r.last = 1;
            pending.push_back(r);
         end else begin
            pending[pending.size() - 1].last = 1;
         end
      end else if (q.kind == pts_pkg::KIND_QUERY) begin
         sk = skew_check(q.now_sec, q.now_usec);
         found = 0;
         best = 0;
         for (int i = 0; i < 16; i++)
            if (valid[i] && (!found || next[i] < best)) begin
               found = 1;
               best = next[i];
            end
         if (!found) w = 2000;
         else if (best < now_us) w = 0;
         else if (best - now_us >= 2000000) w = 2000;
         else w = (best - now_us) / 1000;
         if (w < 1) w = 1;
         r.wait_ms = 11'(w);
         r.skew_seen = sk;
         pending.push_back(r);
      end else begin
         pending.push_back(r);
      end
   endfunction

   function void check_result(pts_pkg::rsp_type got);
      pts_pkg::rsp_type exp_r;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %p", $time, got);
         failed = 1;
         return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status || got.slot !== exp_r.slot ||
          got.fired !== exp_r.fired || got.calls_left !== exp_r.calls_left ||
          got.wait_ms !== exp_r.wait_ms || got.skew_seen !== exp_r.skew_seen ||
          got.last !== exp_r.last) begin
         $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
         failed = 1;
      end
   endfunction
endclass

module periodic_timer_scheduler_tb import pts_pkg::*; ();

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   timer_table_model table_model;

   // Simulated wall clock; it mostly advances in small steps so that timers
   // come due, with occasional jumps that cause clock skew.
   bit [31:0] wall_sec;
   bit [19:0] wall_usec;
   int        stall_mode;

   periodic_timer_scheduler dut (.*);

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Every accepted result is checked at the rising edge.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) table_model.check_result(rsp_data);

   // The receiver stalls on a pattern that changes mode now and then, so
   // there are long stretches of no stalls as well as heavy back-pressure.
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= 1'(($time / 64) % 2);
      endcase
   end

   // Writes the offset register through a setup and an access cycle.
   task automatic write_offset(int hours);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {CSR_UTC_OFFSET, 2'b00};
      csr_pwdata <= 32'(hours);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      table_model.offset_hours = hours;
   endtask

   // Presents one transaction and holds it until accepted; called at negedge.
   task automatic send(req_type q);
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      table_model.note_request(q);
      @(negedge clock);
   endtask

   // Waits for all results, then long enough that the block is idle.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (table_model.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic req_type make(logic [1:0] k, bit [31:0] ivl, bit [16:0] al,
                                    bit [30:0] mc);
      req_type q;
      q.kind = k;
      q.now_sec = wall_sec;
      q.now_usec = wall_usec;
      q.interval_ms = ivl;
      q.align_seconds = al;
      q.call_limit = mc;
      return q;
   endfunction

   // Moves the wall clock forward, rarely by a skew-sized jump either way.
   task automatic tick_clock();
      int r;
      longint us;
      r = $urandom_range(0, 99);
      if (r < 4) wall_sec = wall_sec + $urandom_range(10, 100000);
      else if (r < 7) wall_sec = wall_sec - $urandom_range(10, 100000);
      else if (r < 8) wall_sec = $urandom;
      else begin
         us = longint'(wall_usec) + $urandom_range(0, 900000);
         wall_sec = wall_sec + 32'(us / 1000000)
                    + (($urandom_range(0, 9) == 0) ? 32'd1 : 32'd0);
         wall_usec = 20'(us % 1000000);
      end
      if ($urandom_range(0, 49) == 0) wall_usec = 20'($urandom_range(0, 20'hFFFFF));
   endtask

   function automatic req_type random_item();
      int r;
      bit [31:0] ivl;
      bit [16:0] al;
      bit [30:0] mc;
      logic [1:0] k;
      r = $urandom_range(0, 99);
      if (r < 35) k = KIND_ADD;
      else if (r < 70) k = KIND_RUN;
      else if (r < 97) k = KIND_QUERY;
      else k = 2'd3;
      r = $urandom_range(0, 19);
      if (r == 0) ivl = 0;
      else if (r == 1) ivl = $urandom;
      else if (r < 8) ivl = $urandom_range(1, 999);
      else ivl = $urandom_range(1000, 5000);
      r = $urandom_range(0, 9);
      al = (r < 5) ? 17'd0 : (r < 9) ? 17'($urandom_range(1, 120))
                                     : 17'($urandom_range(0, 17'h1FFFF));
      r = $urandom_range(0, 9);
      mc = (r < 4) ? 31'd0 : (r < 9) ? 31'($urandom_range(1, 4)) : 31'($urandom);
      return make(k, ivl, al, mc);
   endfunction

   initial begin
      int offsets [5];
      int gap;
      req_type q;
      table_model = new();
      table_model.clear();
      offsets = '{-23, 23, 5, -32, 31};
      stall_mode = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      wall_sec = 32'd1000;
      wall_usec = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty table cases, rejects, a full table, alignment,
      // many due timers at once, field extremes and the unused kind.
      @(negedge clock);
      send(make(KIND_RUN, 0, 0, 0));
      send(make(KIND_QUERY, 0, 0, 0));
      send(make(KIND_ADD, 0, 17'd86400, 31'h7FFFFFFF));
      send(make(2'd3, 32'hFFFFFFFF, 17'h1FFFF, 31'h7FFFFFFF));
      send(make(KIND_ADD, 32'hFFFFFFFF, 17'h1FFFF, 31'h7FFFFFFF));
      send(make(KIND_ADD, 1000, 17'd60, 2));
      send(make(KIND_ADD, 999, 17'd60, 1));
      for (int i = 0; i < 14; i++) send(make(KIND_ADD, 1, 0, 0));
      send(make(KIND_ADD, 5, 0, 0));
      send(make(KIND_ADD, 0, 0, 0));
      wall_sec = wall_sec + 2;
      send(make(KIND_RUN, 0, 0, 0));
      send(make(KIND_QUERY, 0, 0, 0));
      wall_sec = 32'hFFFFFFFF;
      wall_usec = 20'hFFFFF;
      send(make(KIND_RUN, 0, 0, 0));
      send(make(KIND_QUERY, 0, 0, 0));
      drain();

      // Random part, in phases with different offsets. Each phase restarts
      // from a clean table by letting limited timers run out is not possible,
      // so the table simply carries over between phases.
      for (int ph = 0; ph < 5; ph++) begin
         write_offset(offsets[ph]);
         wall_sec = $urandom;
         @(negedge clock);
         for (int n = 0; n < 92; n++) begin
            tick_clock();
            q = random_item();
            send(q);
            // Bursts of random length separated by random gaps.
            if ($urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               gap = $urandom_range(1, 40);
               repeat (gap) @(negedge clock);
            end
         end
         drain();
      end

      if (!table_model.failed && table_model.pending.size() == 0)
         $display("PASS periodic_timer_scheduler");
      else
         $display("FAIL periodic_timer_scheduler");
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL periodic_timer_scheduler");
      $finish;
   end
endmodule
